@@ hdl/pwmcap_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the dual pwm capture block
// no dependencies
package pwmcap_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int GAIN_W      = 17;
	localparam int OFFSET_W    = 24;
	localparam int THRESH_W    = 16;
	localparam int LIMIT_W     = 4;
	localparam int REJ_W       = 5;
	localparam int ANGLE_W     = 32;

	// register indexes of the config port
	localparam logic [CFG_INDEX_W-1:0] REG_JUMP_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REJECT_LIMIT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_GAIN     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_OFFSET   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BETA_GAIN      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BETA_OFFSET    = 3'd5;

	// register reset values
	localparam logic [THRESH_W-1:0]        RST_JUMP_THRESHOLD = 16'd250;
	localparam logic [LIMIT_W-1:0]         RST_REJECT_LIMIT   = 4'd2;
	localparam logic [GAIN_W-1:0]          RST_ALPHA_GAIN     = 17'd24274;
	localparam logic signed [OFFSET_W-1:0] RST_ALPHA_OFFSET   = -24'sd16435;
	localparam logic [GAIN_W-1:0]          RST_BETA_GAIN      = 17'd23167;
	localparam logic signed [OFFSET_W-1:0] RST_BETA_OFFSET    = 24'sd9423;

	localparam logic [REJ_W-1:0] REJ_MAX = 5'd31;

	typedef struct packed {
		logic [THRESH_W-1:0] jump_threshold;
		logic [LIMIT_W-1:0]  reject_limit;
	} lane_cfg_t;

endpackage

@@ hdl/dual_pwm_capture_outlier_filter_top.sv @@
`timescale 1ns / 1ps
// top level of the dual pwm capture block: config registers, two lanes,
// merge of the ok flags and the conversion pipeline; depends on pwmcap_pkg,
// pwmcap_lane, pwmcap_conv
//
//  channel   handshake              payload
//  in        in_valid / in_ready    alpha_level, beta_level, host_read
//  out       out_valid / out_ready  alpha_angle, beta_angle, alpha_valid, beta_valid
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one tick per clock unless a stalled output holds it; from input to output register:
// lane state updates in the accept cycle, the gain product takes one stage, the
// round/offset/saturate step feeds the output register, which holds the angles
// each stage has its own valid bit, so a stalled output only stops the stages behind it
// cfg_ready is always high; reset clears registers to their documented defaults
module dual_pwm_capture_outlier_filter_top #(
	parameter int WIDTH_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        alpha_level,
	input  logic                                        beta_level,
	input  logic                                        host_read,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [pwmcap_pkg::ANGLE_W-1:0]       alpha_angle,
	output logic signed [pwmcap_pkg::ANGLE_W-1:0]       beta_angle,
	output logic                                        alpha_valid,
	output logic                                        beta_valid,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [pwmcap_pkg::CFG_INDEX_W-1:0]          cfg_index,
	input  logic [pwmcap_pkg::CFG_DATA_W-1:0]           cfg_data
);
	import pwmcap_pkg::*;

	lane_cfg_t                   lane_cfg_q;
	logic [GAIN_W-1:0]           alpha_gain_q;
	logic signed [OFFSET_W-1:0]  alpha_offset_q;
	logic [GAIN_W-1:0]           beta_gain_q;
	logic signed [OFFSET_W-1:0]  beta_offset_q;

	logic                  in_acc;
	logic                  rdy2;
	logic                  rdy_o;
	logic [WIDTH_BITS-1:0] alpha_width_now;
	logic [WIDTH_BITS-1:0] beta_width_now;
	logic                  alpha_ok_now;
	logic                  beta_ok_now;

	logic                  v1_s1;
	logic [WIDTH_BITS-1:0] alpha_width_s1;
	logic [WIDTH_BITS-1:0] beta_width_s1;
	logic                  alpha_ok_s1;
	logic                  beta_ok_s1;
	logic                  upd_s1;

	logic                  v2_s2;
	logic                  alpha_ok_s2;
	logic                  beta_ok_s2;
	logic                  upd_s2;

	logic signed [ANGLE_W-1:0] alpha_conv;
	logic signed [ANGLE_W-1:0] beta_conv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_cfg_q.jump_threshold <= RST_JUMP_THRESHOLD;
			lane_cfg_q.reject_limit   <= RST_REJECT_LIMIT;
			alpha_gain_q              <= RST_ALPHA_GAIN;
			alpha_offset_q            <= RST_ALPHA_OFFSET;
			beta_gain_q               <= RST_BETA_GAIN;
			beta_offset_q             <= RST_BETA_OFFSET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_JUMP_THRESHOLD: lane_cfg_q.jump_threshold <= cfg_data[THRESH_W-1:0];
				REG_REJECT_LIMIT:   lane_cfg_q.reject_limit   <= cfg_data[LIMIT_W-1:0];
				REG_ALPHA_GAIN:     alpha_gain_q              <= cfg_data[GAIN_W-1:0];
				REG_ALPHA_OFFSET:   alpha_offset_q            <= $signed(cfg_data);
				REG_BETA_GAIN:      beta_gain_q               <= cfg_data[GAIN_W-1:0];
				REG_BETA_OFFSET:    beta_offset_q             <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// each stage may advance when it is empty or the next one advances
	assign rdy_o    = !out_valid || out_ready;
	assign rdy2     = !v2_s2 || rdy_o;
	assign in_ready = !v1_s1 || rdy2;
	assign in_acc   = in_valid && in_ready;

	pwmcap_lane #(.WIDTH_BITS(WIDTH_BITS)) u_alpha_lane (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.level     (alpha_level),
		.host_read (host_read),
		.cfg       (lane_cfg_q),
		.width_now (alpha_width_now),
		.ok_now    (alpha_ok_now)
	);

	pwmcap_lane #(.WIDTH_BITS(WIDTH_BITS)) u_beta_lane (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.level     (beta_level),
		.host_read (host_read),
		.cfg       (lane_cfg_q),
		.width_now (beta_width_now),
		.ok_now    (beta_ok_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v1_s1 <= in_valid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			alpha_width_s1 <= alpha_width_now;
			beta_width_s1  <= beta_width_now;
			alpha_ok_s1    <= alpha_ok_now;
			beta_ok_s1     <= beta_ok_now;
			// either lane ok refreshes both angles
			upd_s1         <= alpha_ok_now || beta_ok_now;
		end
		if (rdy2 && v1_s1) begin
			alpha_ok_s2 <= alpha_ok_s1;
			beta_ok_s2  <= beta_ok_s1;
			upd_s2      <= upd_s1;
		end
	end

	pwmcap_conv #(.WIDTH_BITS(WIDTH_BITS)) u_alpha_conv (
		.clk    (clk),
		.load   (rdy2 && v1_s1),
		.width  (alpha_width_s1),
		.gain   (alpha_gain_q),
		.offset (alpha_offset_q),
		.angle  (alpha_conv)
	);

	pwmcap_conv #(.WIDTH_BITS(WIDTH_BITS)) u_beta_conv (
		.clk    (clk),
		.load   (rdy2 && v1_s1),
		.width  (beta_width_s1),
		.gain   (beta_gain_q),
		.offset (beta_offset_q),
		.angle  (beta_conv)
	);

	// output register doubles as the held angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			alpha_angle <= '0;
			beta_angle  <= '0;
			alpha_valid <= 1'b0;
			beta_valid  <= 1'b0;
		end else if (rdy_o) begin
			out_valid <= v2_s2;
			if (v2_s2) begin
				alpha_valid <= alpha_ok_s2;
				beta_valid  <= beta_ok_s2;
				if (upd_s2) begin
					alpha_angle <= alpha_conv;
					beta_angle  <= beta_conv;
				end
			end
		end
	end

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> in_ready) else $error("empty first stage refuses input");
	a_stage2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && !rdy_o) |=> v2_s2) else $error("stalled stage two lost its transaction");
	a_angle_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy_o && v2_s2 && upd_s2) |=> ($stable(alpha_angle) && $stable(beta_angle)))
		else $error("held angle changed without an update");
	a_ok_implies_update: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && (alpha_ok_s2 || beta_ok_s2)) |-> upd_s2)
		else $error("ok transaction without angle update");

endmodule

@@ hdl/pwmcap_lane.sv @@
`timescale 1ns / 1ps
// one capture lane: pulse width counter, outlier check and ok flag
// depends on pwmcap_pkg
module pwmcap_lane #(
	parameter int WIDTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   level,
	input  logic                   host_read,
	input  pwmcap_pkg::lane_cfg_t  cfg,
	output logic [WIDTH_BITS-1:0]  width_now,
	output logic                   ok_now
);
	import pwmcap_pkg::*;

	localparam int CMP_W = (WIDTH_BITS > THRESH_W) ? WIDTH_BITS : THRESH_W;

	logic                  last_q;
	logic [WIDTH_BITS-1:0] ticks_q;
	logic [WIDTH_BITS-1:0] latest_q;
	logic [WIDTH_BITS-1:0] acc_q;
	logic                  has_q;
	logic [REJ_W-1:0]      rej_q;
	logic                  ok_q;

	logic [WIDTH_BITS-1:0] ticks_d;
	logic [WIDTH_BITS-1:0] latest_d;
	logic [WIDTH_BITS-1:0] acc_d;
	logic                  has_d;
	logic [REJ_W-1:0]      rej_d;
	logic                  ok_d;
	logic [WIDTH_BITS-1:0] diff;
	logic                  force_acc;
	logic                  too_far;

	always_comb begin
		diff      = (ticks_q >= acc_q) ? (ticks_q - acc_q) : (acc_q - ticks_q);
		force_acc = !has_q || (rej_q > {1'b0, cfg.reject_limit});
		too_far   = CMP_W'(diff) > CMP_W'(cfg.jump_threshold);
		ticks_d   = ticks_q;
		latest_d  = latest_q;
		acc_d     = acc_q;
		has_d     = has_q;
		rej_d     = rej_q;
		ok_d      = ok_q;
		if (level) begin
			if (!last_q) begin
				ticks_d = WIDTH_BITS'(1);
			end else if (ticks_q != '1) begin
				ticks_d = ticks_q + WIDTH_BITS'(1);
			end
		end else if (last_q) begin
			// falling edge closes the pulse
			latest_d = ticks_q;
			if (force_acc || !too_far) begin
				acc_d = ticks_q;
				has_d = 1'b1;
				ok_d  = 1'b1;
				rej_d = '0;
			end else begin
				ok_d = 1'b0;
				if (rej_q != REJ_MAX) begin
					rej_d = rej_q + REJ_W'(1);
				end
			end
		end
	end

	assign width_now = latest_d;
	assign ok_now    = ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			ticks_q  <= '0;
			latest_q <= '0;
			acc_q    <= '0;
			has_q    <= 1'b0;
			rej_q    <= '0;
			ok_q     <= 1'b0;
		end else if (accept) begin
			last_q   <= level;
			ticks_q  <= ticks_d;
			latest_q <= latest_d;
			acc_q    <= acc_d;
			has_q    <= has_d;
			rej_q    <= rej_d;
			// a host read clears the flag after it has been reported
			ok_q     <= ok_d && !host_read;
		end
	end

	a_ok_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ok_q |-> has_q) else $error("lane ok without an accepted width");
	a_rej_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(rej_q != '0) |-> has_q) else $error("lane reject before any accept");
	a_ok_clears_rej: assert property (@(posedge clk) disable iff (!arst_n)
		ok_q |-> (rej_q == '0)) else $error("lane ok with pending rejects");

endmodule

@@ hdl/pwmcap_conv.sv @@
`timescale 1ns / 1ps
// width to angle conversion: registered gain product, then round, offset, saturate
// depends on pwmcap_pkg
module pwmcap_conv #(
	parameter int WIDTH_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     load,
	input  logic [WIDTH_BITS-1:0]                    width,
	input  logic [pwmcap_pkg::GAIN_W-1:0]            gain,
	input  logic signed [pwmcap_pkg::OFFSET_W-1:0]   offset,
	output logic signed [pwmcap_pkg::ANGLE_W-1:0]    angle
);
	import pwmcap_pkg::*;

	localparam int PW  = GAIN_W + WIDTH_BITS;
	localparam int RW  = PW + 1 - 8;
	localparam int SW0 = RW + 2;
	localparam int SW  = (SW0 > ANGLE_W + 1) ? SW0 : ANGLE_W + 1;

	logic [PW-1:0]        prod_s2;
	logic [PW:0]          biased;
	logic [RW-1:0]        rounded;
	logic signed [SW-1:0] sum;
	logic                 in_range;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= PW'(gain) * PW'(width);
		end
	end

	always_comb begin
		// round to nearest, ties upward
		biased   = {1'b0, prod_s2} + (PW+1)'(128);
		rounded  = biased[PW:8];
		sum      = $signed(SW'(rounded)) + SW'(offset);
		in_range = (sum[SW-1:ANGLE_W-1] == '0) || (sum[SW-1:ANGLE_W-1] == '1);
		if (in_range) begin
			angle = sum[ANGLE_W-1:0];
		end else if (sum[SW-1]) begin
			angle = {1'b1, {(ANGLE_W-1){1'b0}}};
		end else begin
			angle = {1'b0, {(ANGLE_W-1){1'b1}}};
		end
	end

endmodule

@@ tb/sv/tb_dual_pwm_capture_outlier_filter_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for dual_pwm_capture_outlier_filter_top: pulse-train stimulus,
// an angle predictor kept in step with the block, and an in-order result scoreboard
// depends on pwmcap_pkg and the block under hdl/
module tb_dual_pwm_capture_outlier_filter_top;
	import pwmcap_pkg::*;

	localparam int WB = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 12;
	localparam int ALPHA = 0;
	localparam int BETA = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;
	localparam longint ANGLE_MAX = 64'sd2147483647;
	localparam longint ANGLE_MIN = -64'sd2147483648;

	typedef struct packed {
		logic alpha;
		logic beta;
		logic rd;
	} pin_sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] alpha_angle;
		logic signed [ANGLE_W-1:0] beta_angle;
		logic                      alpha_valid;
		logic                      beta_valid;
	} vane_reading_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          alpha_level = 1'b0;
	logic                          beta_level = 1'b0;
	logic                          host_read = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [ANGLE_W-1:0]     alpha_angle;
	logic signed [ANGLE_W-1:0]     beta_angle;
	logic                          alpha_valid;
	logic                          beta_valid;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_INDEX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;

	// predictor copy of the settings and lane state
	logic [THRESH_W-1:0]           jump_thr;
	logic [LIMIT_W-1:0]            rej_limit;
	logic [GAIN_W-1:0]             gain [2];
	logic signed [OFFSET_W-1:0]    offset [2];
	logic                          prev_level [2];
	logic [WB-1:0]                 high_cnt [2];
	logic [WB-1:0]                 last_width [2];
	logic [WB-1:0]                 kept_width [2];
	logic                          seen_pulse [2];
	logic [REJ_W-1:0]              rej_cnt [2];
	logic                          lane_ok [2];
	logic signed [ANGLE_W-1:0]     angle_hold [2];

	vane_reading_t                 reading_q [$];
	pin_sample_t                   pin_q [$];
	pin_sample_t                   next_pin;
	int                            ticks_queued = 0;
	int                            ticks_taken = 0;
	int                            mismatches = 0;
	int                            burst_left;
	int                            gap_left;
	int                            stall_mode;
	logic [15:0]                   stall_cnt;

	dual_pwm_capture_outlier_filter_top #(.WIDTH_BITS(WB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.alpha_level(alpha_level),
		.beta_level(beta_level),
		.host_read(host_read),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alpha_angle(alpha_angle),
		.beta_angle(beta_angle),
		.alpha_valid(alpha_valid),
		.beta_valid(beta_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void lane_step(int c, logic lvl);
		longint unsigned w;
		longint unsigned kw;
		longint unsigned d;
		if (lvl) begin
			if (!prev_level[c])
				high_cnt[c] = WB'(1);
			else if (high_cnt[c] != '1)
				high_cnt[c] = high_cnt[c] + WB'(1);
		end else if (prev_level[c]) begin
			// falling edge closes the pulse
			w = 64'(high_cnt[c]);
			kw = 64'(kept_width[c]);
			last_width[c] = high_cnt[c];
			d = (w >= kw) ? w - kw : kw - w;
			if (!seen_pulse[c] || rej_cnt[c] > REJ_W'(rej_limit) || d <= 64'(jump_thr)) begin
				kept_width[c] = high_cnt[c];
				seen_pulse[c] = 1'b1;
				lane_ok[c] = 1'b1;
				rej_cnt[c] = '0;
			end else begin
				lane_ok[c] = 1'b0;
				if (rej_cnt[c] != REJ_MAX)
					rej_cnt[c] = rej_cnt[c] + REJ_W'(1);
			end
		end
		prev_level[c] = lvl;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] scaled_angle(int c);
		longint sum;
		sum = ((longint'(gain[c]) * longint'(last_width[c]) + 128) >>> 8)
			+ longint'(offset[c]);
		if (sum > ANGLE_MAX)
			sum = ANGLE_MAX;
		else if (sum < ANGLE_MIN)
			sum = ANGLE_MIN;
		return sum[ANGLE_W-1:0];
	endfunction

	function automatic void capture_tick(pin_sample_t s);
		vane_reading_t r;
		lane_step(ALPHA, s.alpha);
		lane_step(BETA, s.beta);
		if (lane_ok[ALPHA] || lane_ok[BETA]) begin
			angle_hold[ALPHA] = scaled_angle(ALPHA);
			angle_hold[BETA] = scaled_angle(BETA);
		end
		r.alpha_angle = angle_hold[ALPHA];
		r.beta_angle = angle_hold[BETA];
		r.alpha_valid = lane_ok[ALPHA];
		r.beta_valid = lane_ok[BETA];
		reading_q.push_back(r);
		ticks_taken++;
		// the read shows the flags first, the clear lands after
		if (s.rd) begin
			lane_ok[ALPHA] = 1'b0;
			lane_ok[BETA] = 1'b0;
		end
	endfunction

	function automatic void check_reading();
		vane_reading_t want;
		if (reading_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected reading: alpha %0d beta %0d ok %b%b",
					alpha_angle, beta_angle, alpha_valid, beta_valid);
			return;
		end
		want = reading_q.pop_front();
		if (alpha_angle !== want.alpha_angle || beta_angle !== want.beta_angle ||
				alpha_valid !== want.alpha_valid || beta_valid !== want.beta_valid) begin
			mismatches++;
			if (mismatches <= 10)
				$display("reading mismatch at %0t: exp alpha %0d beta %0d ok %b%b, got alpha %0d beta %0d ok %b%b",
					$realtime, want.alpha_angle, want.beta_angle, want.alpha_valid,
					want.beta_valid, alpha_angle, beta_angle, alpha_valid, beta_valid);
		end
	endfunction

	// sender: bursts of random length, random gaps, some bursts back to back
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			alpha_level <= 1'b0;
			beta_level <= 1'b0;
			host_read <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				capture_tick({alpha_level, beta_level, host_read});
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pin_q.size() != 0) begin
					next_pin = pin_q.pop_front();
					in_valid <= 1'b1;
					alpha_level <= next_pin.alpha;
					beta_level <= next_pin.beta;
					host_read <= next_pin.rd;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: a new random stall pattern is picked each time the low byte of stall_cnt reaches FF
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt <= '0;
			stall_mode <= 0;
		end else begin
			if (out_valid && out_ready)
				check_reading();
			stall_cnt <= stall_cnt + 16'd1;
			if (stall_cnt[7:0] == 8'hFF)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (stall_cnt[3:0] < 4'd11);
				default: out_ready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic push_tick(logic a, logic b, logic rd);
		pin_sample_t s;
		s.alpha = a;
		s.beta = b;
		s.rd = rd;
		pin_q.push_back(s);
		ticks_queued++;
	endtask

	// both lanes start together, each stays high for its width, and the pair ends gap ticks after the longer pulse
	task automatic push_pair(int wa, int wb, int gap, logic rd);
		int n;
		n = ((wa > wb) ? wa : wb) + gap;
		for (int i = 0; i < n; i++)
			push_tick(i < wa, i < wb, rd && (i == n - 1));
	endtask

	function automatic int pick_width(int base, int jit, int wmax);
		int w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: w = base + int'($urandom_range(0, 2 * jit)) - jit;
			6, 7: w = base + 3 * jit + 1 + int'($urandom_range(0, 4 * jit));
			default: w = int'($urandom_range(1, wmax));
		endcase
		return (w < 1) ? 1 : w;
	endfunction

	// independent pulse trains on the two lanes, widths mostly near a drifting base
	task automatic queue_train(int n, int wmax, int jit, int rd_pct);
		int hi_left [2];
		int lo_left [2];
		int base [2];
		logic lvl [2];
		for (int c = 0; c < 2; c++) begin
			base[c] = $urandom_range(1, wmax);
			hi_left[c] = 0;
			lo_left[c] = $urandom_range(0, 3);
		end
		for (int i = 0; i < n; i++) begin
			for (int c = 0; c < 2; c++) begin
				if (hi_left[c] == 0 && lo_left[c] == 0) begin
					if ($urandom_range(0, 7) == 0)
						base[c] = $urandom_range(1, wmax);
					hi_left[c] = pick_width(base[c], jit, wmax);
					lo_left[c] = $urandom_range(1, 6);
				end
				if (hi_left[c] != 0) begin
					lvl[c] = 1'b1;
					hi_left[c]--;
				end else begin
					lvl[c] = 1'b0;
					lo_left[c]--;
				end
			end
			push_tick(lvl[ALPHA], lvl[BETA], $urandom_range(0, 99) < rd_pct);
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_JUMP_THRESHOLD: jump_thr = data[THRESH_W-1:0];
			REG_REJECT_LIMIT:   rej_limit = data[LIMIT_W-1:0];
			REG_ALPHA_GAIN:     gain[ALPHA] = data[GAIN_W-1:0];
			REG_ALPHA_OFFSET:   offset[ALPHA] = data[OFFSET_W-1:0];
			REG_BETA_GAIN:      gain[BETA] = data[GAIN_W-1:0];
			REG_BETA_OFFSET:    offset[BETA] = data[OFFSET_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] lim,
			logic [CFG_DATA_W-1:0] ga, logic [CFG_DATA_W-1:0] oa,
			logic [CFG_DATA_W-1:0] gb, logic [CFG_DATA_W-1:0] ob);
		write_reg(REG_JUMP_THRESHOLD, thr);
		write_reg(REG_REJECT_LIMIT, lim);
		write_reg(REG_ALPHA_GAIN, ga);
		write_reg(REG_ALPHA_OFFSET, oa);
		write_reg(REG_BETA_GAIN, gb);
		write_reg(REG_BETA_OFFSET, ob);
	endtask

	// block is idle once every queued tick is taken and every reading is back
	task automatic drain();
		while (ticks_taken != ticks_queued || reading_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int thr;
		int wmax;
		int jit;
		jump_thr = RST_JUMP_THRESHOLD;
		rej_limit = RST_REJECT_LIMIT;
		gain[ALPHA] = RST_ALPHA_GAIN;
		offset[ALPHA] = RST_ALPHA_OFFSET;
		gain[BETA] = RST_BETA_GAIN;
		offset[BETA] = RST_BETA_OFFSET;
		for (int c = 0; c < 2; c++) begin
			prev_level[c] = 1'b0;
			high_cnt[c] = '0;
			last_width[c] = '0;
			kept_width[c] = '0;
			seen_pulse[c] = 1'b0;
			rej_cnt[c] = '0;
			lane_ok[c] = 1'b0;
			angle_hold[c] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first pulse on each lane, reads while ok is set
		push_pair(1, 3, 1, 1);
		push_pair(2, 1, 1, 0);
		push_pair(0, 0, 1, 1);
		drain();

		// tight threshold: rejects, forced acceptance past the limit, unmapped writes
		load_settings(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(RST_ALPHA_GAIN),
			CFG_DATA_W'(RST_ALPHA_OFFSET), CFG_DATA_W'(RST_BETA_GAIN),
			CFG_DATA_W'(RST_BETA_OFFSET));
		write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
		write_reg(REG_UNMAPPED_HI, '1);
		push_pair(4, 2, 1, 0);
		push_pair(4, 6, 1, 1);
		push_pair(4, 6, 1, 0);
		push_pair(1, 1, 1, 0);
		drain();

		// long pulses with the largest gains and extreme offsets
		load_settings('1, '1, '1, 24'h7FFFFF, '1, 24'h800000);
		push_pair(300, 280, 2, 1);
		push_pair(1, 1, 2, 0);
		drain();

		// zero gains, offsets swapped to the other extremes
		load_settings('0, '0, '0, 24'h800000, '0, 24'h7FFFFF);
		queue_train(150, 12, 1, 10);
		drain();

		for (int p = 0; p < 9; p++) begin
			case (p % 3)
				0: begin
					thr = $urandom_range(0, 3);
					wmax = 12;
					jit = 1;
				end
				1: begin
					thr = $urandom_range(5, 40);
					wmax = 50;
					jit = thr / 2 + 1;
				end
				default: begin
					thr = $urandom_range(0, 65535);
					wmax = 40;
					jit = 5;
				end
			endcase
			// upper data bits are junk that the block must mask
			load_settings(CFG_DATA_W'(thr + ($urandom_range(0, 255) << 16)),
				CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			queue_train(120, wmax, jit, $urandom_range(0, 40));
			drain();
		end

		// broken trains: random levels every tick
		load_settings(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 15)),
			CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
			CFG_DATA_W'($urandom));
		for (int i = 0; i < 120; i++)
			push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0);
		drain();

		if (reading_q.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
